### hw/rtl/ba_pkg.sv
// shared types, constants and helper functions of the buddy allocator
`default_nettype none
package ba_pkg;

  localparam int LEVELS        = 10;
  localparam int MIN_BLOCK_LOG = 4;
  localparam int TOTAL_LOG     = LEVELS - 1 + MIN_BLOCK_LOG;
  localparam int UNIT_W        = LEVELS - 1;
  localparam int UNITS         = 1 << UNIT_W;
  localparam int LINK_W        = LEVELS;
  localparam int NODE_W        = LEVELS;
  localparam int LVL_W         = $clog2(LEVELS);
  localparam int ADDR_W        = 13;
  localparam int SIZE_W        = 15;
  localparam int CNT_W         = 14;
  localparam int REGION        = 1 << TOTAL_LOG;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;

  // link value meaning no neighbor
  localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {UNIT_W{1'b0}}};

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  used_bytes;
    logic [CNT_W-1:0]  peak_bytes;
  } out_item_t;

  typedef enum logic [2:0] {
    K_ALLOC,
    K_FREE,
    K_RESET,
    K_ZERO,
    K_BIG,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [LVL_W-1:0]  want;
    logic [UNIT_W-1:0] unit;
  } cmd_t;

  // tree node of the block at a level that starts at a min block
  function automatic logic [NODE_W-1:0] node_of(logic [LVL_W-1:0] lvl,
                                                logic [UNIT_W-1:0] unit);
    logic [NODE_W-1:0] base;
    logic [NODE_W-1:0] off;
    base = (NODE_W'(1) << lvl) - NODE_W'(1);
    off  = NODE_W'(unit >> (UNIT_W - int'(lvl)));
    return base + off;
  endfunction

  // half a block of the parent level, in min blocks
  function automatic logic [UNIT_W-1:0] unit_half(logic [LVL_W-1:0] lvl);
    logic [UNIT_W-1:0] one_v;
    one_v = UNIT_W'(1);
    return one_v << (UNIT_W - int'(lvl));
  endfunction

  function automatic logic aligned(logic [UNIT_W-1:0] unit, logic [LVL_W-1:0] lvl);
    logic [UNIT_W:0] m;
    m = ((UNIT_W+1)'(1) << (UNIT_W - int'(lvl))) - (UNIT_W+1)'(1);
    return ({1'b0, unit} & m) == '0;
  endfunction

  function automatic logic [CNT_W-1:0] level_bytes(logic [LVL_W-1:0] lvl);
    logic [CNT_W-1:0] one_v;
    one_v = CNT_W'(1);
    return one_v << (TOTAL_LOG - int'(lvl));
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ba_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/ba_front.sv
// front end: takes items, classifies them and queues commands
`default_nettype none
module ba_front #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire ba_pkg::in_item_t in_item,
  output logic                  cmd_valid,
  input  wire logic             cmd_take,
  output ba_pkg::cmd_t          cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ba_pkg::cmd_t  q_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  ba_pkg::cmd_t  cls;
  logic          acc, take;

  always_comb begin
    cls.kind = ba_pkg::K_NOP;
    cls.want = '0;
    cls.unit = in_item.free_address[ba_pkg::ADDR_W-1:ba_pkg::MIN_BLOCK_LOG];
    case (in_item.opcode)
      ba_pkg::OP_ALLOC: begin
        if (in_item.request_size == '0) begin
          cls.kind = ba_pkg::K_ZERO;
        end else if (int'(in_item.request_size) > ba_pkg::REGION) begin
          cls.kind = ba_pkg::K_BIG;
        end else begin
          cls.kind = ba_pkg::K_ALLOC;
          // deepest level whose block still holds the request
          for (int l = 0; l < ba_pkg::LEVELS; l++) begin
            if (int'(in_item.request_size) <= (1 << (ba_pkg::TOTAL_LOG - l))) begin
              cls.want = ba_pkg::LVL_W'(l);
            end
          end
        end
      end
      ba_pkg::OP_FREE: begin
        if (in_item.free_address[ba_pkg::MIN_BLOCK_LOG-1:0] == '0) begin
          cls.kind = ba_pkg::K_FREE;
        end
      end
      ba_pkg::OP_RESET: begin
        cls.kind = ba_pkg::K_RESET;
      end
      default: begin
        cls.kind = ba_pkg::K_NOP;
      end
    endcase
  end

  assign full      = (cnt_r == CW'(DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];
  assign acc       = push && !full;
  assign take      = cmd_take && cmd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (acc) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (take) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (acc && !take) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (take && !acc) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ba_back.sv
// back end: free lists, tree and sequencer that carry out commands
`default_nettype none
module ba_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  output logic               cmd_take,
  input  wire ba_pkg::cmd_t  cmd,
  output logic               empty,
  input  wire logic          pop,
  output ba_pkg::out_item_t  out_item
);

  localparam int LV  = ba_pkg::LEVELS;
  localparam int UW  = ba_pkg::UNIT_W;
  localparam int LW  = ba_pkg::LINK_W;
  localparam int NW  = ba_pkg::NODE_W;
  localparam int VW  = ba_pkg::LVL_W;
  localparam int CW  = ba_pkg::CNT_W;
  localparam int AW  = ba_pkg::ADDR_W;

  typedef enum logic [13:0] {
    S_CLEAR = 14'h0001,
    S_IDLE  = 14'h0002,
    S_POP0  = 14'h0004,
    S_POP1  = 14'h0008,
    S_PUSH0 = 14'h0010,
    S_PUSH1 = 14'h0020,
    S_FRD   = 14'h0040,
    S_FBL   = 14'h0080,
    S_FTREE = 14'h0100,
    S_MCHK  = 14'h0200,
    S_MTST  = 14'h0400,
    S_EHEAD = 14'h0800,
    S_EMID  = 14'h1000,
    S_DONE  = 14'h2000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic              rstres_r, rstres_nxt;
  logic [UW-1:0]     head_r [LV];
  logic [UW-1:0]     head_nxt [LV];
  logic [LV-1:0]     ne_r, ne_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic [CW-1:0]     peak_r, peak_nxt;
  logic [VW-1:0]     lvl_r, lvl_nxt;
  logic [VW-1:0]     want_r, want_nxt;
  logic [UW-1:0]     unit_r, unit_nxt;
  logic [UW-1:0]     buddy_r, buddy_nxt;
  logic [UW-1:0]     pu_r, pu_nxt;
  logic              second_r, second_nxt;
  logic              mfree_r, mfree_nxt;
  logic              pne_r, pne_nxt;
  logic [UW-1:0]     phead_r, phead_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              ovld_r, ovld_nxt;
  ba_pkg::out_item_t out_r, out_nxt;

  logic          nx_we, pv_we, tr_we, bl_we;
  logic [UW-1:0] nx_wa, pv_wa, bl_wa, nx_ra, pv_ra, bl_ra;
  logic [NW-1:0] tr_wa, tr_ra;
  logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic [0:0]    tr_wd, tr_rd;
  logic [VW-1:0] bl_wd, bl_rd;

  logic [VW-1:0] found;
  logic          hit;
  logic [CW-1:0] sum;
  logic [UW-1:0] nu;

  ba_ram #(.WIDTH(LW), .DEPTH(ba_pkg::UNITS)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
  );
  ba_ram #(.WIDTH(LW), .DEPTH(ba_pkg::UNITS)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
  );
  ba_ram #(.WIDTH(1), .DEPTH(1 << NW)) u_tree (
    .clk(clk), .we(tr_we), .waddr(tr_wa), .wdata(tr_wd), .raddr(tr_ra), .rdata(tr_rd)
  );
  ba_ram #(.WIDTH(VW), .DEPTH(ba_pkg::UNITS)) u_lvl (
    .clk(clk), .we(bl_we), .waddr(bl_wa), .wdata(bl_wd), .raddr(bl_ra), .rdata(bl_rd)
  );

  // deepest non-empty level at or above the wanted one
  always_comb begin
    found = '0;
    hit   = 1'b0;
    for (int l = 0; l < LV; l++) begin
      if (VW'(l) <= cmd.want && ne_r[l]) begin
        found = VW'(l);
        hit   = 1'b1;
      end
    end
  end

  assign sum = used_r + ba_pkg::level_bytes(cmd.want);
  assign nu  = (unit_r < buddy_r) ? unit_r : buddy_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rstres_nxt = rstres_r;
    head_nxt   = head_r;
    ne_nxt     = ne_r;
    used_nxt   = used_r;
    peak_nxt   = peak_r;
    lvl_nxt    = lvl_r;
    want_nxt   = want_r;
    unit_nxt   = unit_r;
    buddy_nxt  = buddy_r;
    pu_nxt     = pu_r;
    second_nxt = second_r;
    mfree_nxt  = mfree_r;
    pne_nxt    = pne_r;
    phead_nxt  = phead_r;
    st_nxt     = st_r;
    addr_nxt   = addr_r;
    ovld_nxt   = ovld_r;
    out_nxt    = out_r;
    cmd_take   = 1'b0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = '0;
    tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = '0;
    bl_we = 1'b0; bl_wa = '0; bl_wd = '0; bl_ra = '0;

    if (pop && ovld_r) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        tr_we = 1'b1;
        tr_wa = cnt_r;
        if (cnt_r < NW'(ba_pkg::UNITS)) begin
          bl_we = 1'b1;
          bl_wa = cnt_r[UW-1:0];
        end
        // whole region sits alone on level 0
        if (cnt_r == '0) begin
          nx_we = 1'b1;
          nx_wd = ba_pkg::LINK_NONE;
          pv_we = 1'b1;
          pv_wd = ba_pkg::LINK_NONE;
        end
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == {NW{1'b1}}) begin
          state_nxt = rstres_r ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          st_nxt   = ba_pkg::ST_OK;
          addr_nxt = '0;
          state_nxt = S_DONE;
          case (cmd.kind)
            ba_pkg::K_ZERO: begin
              st_nxt = ba_pkg::ST_ZERO;
            end
            ba_pkg::K_BIG: begin
              st_nxt = ba_pkg::ST_NOFIT;
            end
            ba_pkg::K_RESET: begin
              for (int l = 0; l < LV; l++) begin
                head_nxt[l] = '0;
              end
              ne_nxt     = LV'(1);
              used_nxt   = '0;
              peak_nxt   = '0;
              cnt_nxt    = '0;
              rstres_nxt = 1'b1;
              state_nxt  = S_CLEAR;
            end
            ba_pkg::K_ALLOC: begin
              if (hit) begin
                used_nxt  = sum;
                peak_nxt  = (peak_r < sum) ? sum : peak_r;
                lvl_nxt   = found;
                want_nxt  = cmd.want;
                state_nxt = S_POP0;
              end else begin
                st_nxt = ba_pkg::ST_NOFIT;
              end
            end
            ba_pkg::K_FREE: begin
              unit_nxt  = cmd.unit;
              state_nxt = S_FRD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_POP0: begin
        nx_ra     = head_r[lvl_r];
        unit_nxt  = head_r[lvl_r];
        state_nxt = S_POP1;
      end

      S_POP1: begin
        if (nx_rd[LW-1]) begin
          ne_nxt[lvl_r] = 1'b0;
        end else begin
          head_nxt[lvl_r] = nx_rd[UW-1:0];
          pv_we = 1'b1;
          pv_wa = nx_rd[UW-1:0];
          pv_wd = ba_pkg::LINK_NONE;
        end
        tr_we = 1'b1;
        tr_wa = ba_pkg::node_of(lvl_r, unit_r);
        tr_wd = 1'b1;
        if (lvl_r != want_r) begin
          lvl_nxt    = lvl_r + VW'(1);
          pu_nxt     = unit_r;
          second_nxt = 1'b0;
          mfree_nxt  = 1'b0;
          state_nxt  = S_PUSH0;
        end else begin
          addr_nxt  = {unit_r, {ba_pkg::MIN_BLOCK_LOG{1'b0}}};
          state_nxt = S_DONE;
        end
      end

      S_PUSH0: begin
        pv_we = 1'b1;
        pv_wa = pu_r;
        pv_wd = ba_pkg::LINK_NONE;
        nx_we = 1'b1;
        nx_wa = pu_r;
        nx_wd = ne_r[lvl_r] ? {1'b0, head_r[lvl_r]} : ba_pkg::LINK_NONE;
        tr_we = 1'b1;
        tr_wa = ba_pkg::node_of(lvl_r, pu_r);
        tr_wd = 1'b0;
        bl_we = 1'b1;
        bl_wa = pu_r;
        bl_wd = lvl_r;
        pne_nxt         = ne_r[lvl_r];
        phead_nxt       = head_r[lvl_r];
        head_nxt[lvl_r] = pu_r;
        ne_nxt[lvl_r]   = 1'b1;
        state_nxt       = S_PUSH1;
      end

      S_PUSH1: begin
        if (pne_r) begin
          pv_we = 1'b1;
          pv_wa = phead_r;
          pv_wd = {1'b0, pu_r};
        end
        if (mfree_r) begin
          state_nxt = S_DONE;
        end else if (!second_r) begin
          second_nxt = 1'b1;
          pu_nxt     = unit_r | ba_pkg::unit_half(lvl_r);
          state_nxt  = S_PUSH0;
        end else begin
          state_nxt = S_POP0;
        end
      end

      S_FRD: begin
        bl_ra     = unit_r;
        state_nxt = S_FBL;
      end

      S_FBL: begin
        lvl_nxt = bl_rd;
        tr_ra   = ba_pkg::node_of(bl_rd, unit_r);
        if ({1'b0, bl_rd} < (VW+1)'(LV) && ba_pkg::aligned(unit_r, bl_rd)) begin
          state_nxt = S_FTREE;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_FTREE: begin
        if (tr_rd[0]) begin
          used_nxt  = used_r - ba_pkg::level_bytes(lvl_r);
          state_nxt = S_MCHK;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_MCHK: begin
        if (lvl_r == '0) begin
          pu_nxt    = unit_r;
          mfree_nxt = 1'b1;
          state_nxt = S_PUSH0;
        end else begin
          buddy_nxt = unit_r ^ ba_pkg::unit_half(lvl_r);
          tr_ra     = ba_pkg::node_of(lvl_r, unit_r ^ ba_pkg::unit_half(lvl_r));
          state_nxt = S_MTST;
        end
      end

      S_MTST: begin
        nx_ra = buddy_r;
        pv_ra = buddy_r;
        if (tr_rd[0]) begin
          pu_nxt    = unit_r;
          mfree_nxt = 1'b1;
          state_nxt = S_PUSH0;
        end else if (ne_r[lvl_r] && head_r[lvl_r] == buddy_r) begin
          state_nxt = S_EHEAD;
        end else begin
          state_nxt = S_EMID;
        end
      end

      S_EHEAD: begin
        if (nx_rd[LW-1]) begin
          ne_nxt[lvl_r] = 1'b0;
        end else begin
          head_nxt[lvl_r] = nx_rd[UW-1:0];
          pv_we = 1'b1;
          pv_wa = nx_rd[UW-1:0];
          pv_wd = ba_pkg::LINK_NONE;
        end
        tr_we     = 1'b1;
        tr_wa     = ba_pkg::node_of(lvl_r, unit_r);
        bl_we     = 1'b1;
        bl_wa     = nu;
        bl_wd     = lvl_r - VW'(1);
        unit_nxt  = nu;
        lvl_nxt   = lvl_r - VW'(1);
        state_nxt = S_MCHK;
      end

      S_EMID: begin
        // unlink the buddy from the middle of its list
        nx_we = 1'b1;
        nx_wa = pv_rd[UW-1:0];
        nx_wd = nx_rd;
        if (!nx_rd[LW-1]) begin
          pv_we = 1'b1;
          pv_wa = nx_rd[UW-1:0];
          pv_wd = pv_rd;
        end
        tr_we     = 1'b1;
        tr_wa     = ba_pkg::node_of(lvl_r, unit_r);
        bl_we     = 1'b1;
        bl_wa     = nu;
        bl_wd     = lvl_r - VW'(1);
        unit_nxt  = nu;
        lvl_nxt   = lvl_r - VW'(1);
        state_nxt = S_MCHK;
      end

      S_DONE: begin
        if (!ovld_r || pop) begin
          out_nxt.status        = st_r;
          out_nxt.block_address = addr_r;
          out_nxt.used_bytes    = used_r;
          out_nxt.peak_bytes    = peak_r;
          ovld_nxt   = 1'b1;
          rstres_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign empty    = !ovld_r;
  assign out_item = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      cnt_r    <= '0;
      rstres_r <= 1'b0;
      for (int l = 0; l < LV; l++) begin
        head_r[l] <= '0;
      end
      ne_r     <= LV'(1);
      used_r   <= '0;
      peak_r   <= '0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rstres_r <= rstres_nxt;
      head_r   <= head_nxt;
      ne_r     <= ne_nxt;
      used_r   <= used_nxt;
      peak_r   <= peak_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r    <= lvl_nxt;
    want_r   <= want_nxt;
    unit_r   <= unit_nxt;
    buddy_r  <= buddy_nxt;
    pu_r     <= pu_nxt;
    second_r <= second_nxt;
    mfree_r  <= mfree_nxt;
    pne_r    <= pne_nxt;
    phead_r  <= phead_nxt;
    st_r     <= st_nxt;
    addr_r   <= addr_nxt;
    out_r    <= out_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/buddy_allocator.sv
// top level of the buddy allocator
//
// Binary buddy allocator over a region of 2^13 bytes in 16-byte min blocks.
// Input queue: in_item is taken at a clock edge with push high and full low.
// Opcodes: allocate, free, reset to one whole free block.
// Result queue: the oldest result sits on out_item while empty is low and
// leaves at an edge with pop high and empty low. Every item gives one result.
// A command queue of CMDQ_DEPTH entries sits between the classifying front
// and the sequencer, so items keep flowing in while a result waits.
// Reset (rst_n low) and a reset item start a clearing pass over the tree
// and level memories; items are queued but not worked on meanwhile, and
// the reset item reports after the pass with zero counts.
// While the receiver stalls, one finished result is held and the sequencer
// waits with the next one; the input queue fills and then raises full.
`default_nettype none
module buddy_allocator #(
  parameter int CMDQ_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire ba_pkg::in_item_t  in_item,
  output logic                   empty,
  input  wire logic              pop,
  output ba_pkg::out_item_t      out_item
);

  logic         cmd_valid;
  logic         cmd_take;
  ba_pkg::cmd_t cmd;

  ba_front #(.DEPTH(CMDQ_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  ba_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

### hw/rtl/ba_checker.sv
// port level checks of the buddy allocator and their bind
`default_nettype none
module ba_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              empty,
  input wire logic              pop,
  input wire ba_pkg::out_item_t out_item
);

  // no result is left over from before a reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present right after reset");

  // only an item with status ok may carry an address
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status != ba_pkg::ST_OK) |-> out_item.block_address == '0)
    else $error("address on a failed item");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.used_bytes <= out_item.peak_bytes
                && out_item.peak_bytes <= ba_pkg::CNT_W'(ba_pkg::REGION)))
    else $error("used or peak count out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind buddy_allocator ba_checker u_ba_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
`default_nettype wire
